// ===== sv/assert_macros.svh =====
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define BHC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: check failed");
`define BHC_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define BHC_ASSERT(lbl, prop)
`define BHC_NEVER(lbl, expr)
`endif

`endif

// ===== sv/bhc_pkg.sv =====
`timescale 1ns / 1ps

package bhc_pkg;

    typedef logic [11:0]        duty_t;
    typedef logic [11:0]        adc_t;
    typedef logic signed [11:0] cmd_t;
    typedef logic [2:0]         pos_t;
    typedef logic signed [12:0] phase_t;

    localparam int   CMD_LIMIT     = 1125;
    localparam int   DUTY_MARGIN   = 10;
    localparam adc_t OFFSET_RESET  = 12'd2000;
    localparam adc_t LIMIT_RESET   = 12'd4095;
    localparam int   PHASE_SAT     = 4095;

    localparam pos_t POS_NONE = 3'd0;
    localparam pos_t POS_1    = 3'd1;
    localparam pos_t POS_2    = 3'd2;
    localparam pos_t POS_3    = 3'd3;
    localparam pos_t POS_4    = 3'd4;
    localparam pos_t POS_5    = 3'd5;
    localparam pos_t POS_6    = 3'd6;

    // hall code a + 2b + 4c to commutation step
    function automatic pos_t hall_step(input logic [2:0] code);
        pos_t p;
        case (code)
            3'd1:    p = POS_3;
            3'd2:    p = POS_5;
            3'd3:    p = POS_4;
            3'd4:    p = POS_1;
            3'd5:    p = POS_2;
            3'd6:    p = POS_6;
            default: p = POS_NONE;
        endcase
        return p;
    endfunction

    // signed odometer increment for a move from last to cur
    function automatic logic signed [2:0] odo_step(input pos_t last, input pos_t cur);
        logic signed [4:0] d;
        logic signed [2:0] s;
        d = $signed({2'b00, last}) - $signed({2'b00, cur});
        if (d < 0)
            d = d + 5'sd6;
        if (d >= 5'sd6)
            d = d - 5'sd6;
        case (d)
            5'sd1:   s = 3'sd1;
            5'sd2:   s = 3'sd2;
            5'sd4:   s = -3'sd2;
            5'sd5:   s = -3'sd1;
            default: s = 3'sd0;
        endcase
        return s;
    endfunction

    // phase value around the half period, clamped to margin..period-margin
    function automatic duty_t duty_clamp(input phase_t v, input duty_t half,
                                         input duty_t hi);
        logic signed [13:0] d;
        d = 14'(v) + $signed({2'b00, half});
        if (d < 14'sd10)
            d = 14'sd10;
        if (d > $signed({2'b00, hi}))
            d = $signed({2'b00, hi});
        return d[11:0];
    endfunction

endpackage

// ===== sv/bldc_hall_block_commutation_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Six-step hall commutation, one input word per PWM period.
// Input channel: hall_a/b/c, current_sample, enable, timed_out, pwm_command
// with in_valid / in_stall. Output channel: duty_a/b/c, output_on, position,
// odometer, speed_period, speed_reverse with out_valid / out_stall.
// Configuration: cfg_wr_en writes cfg_wr_data into the current limit.
// A word is captured in an input register and processed from there; its
// result lands in the output register and raises out_valid. One word per
// cycle is sustained while out_stall does not hold it back; the single pass
// through the scaling, filter and clamp logic between the two registers sets
// that rate. The first CALIB_ITEMS words only average the current offset and
// produce no output word.
// Reset clears the filter, odometer, speed tracking and calibration count,
// sets the offset to 2000 and the limit to 4095.
// While out_stall holds a full output register, the input register keeps
// its word and in_stall is raised; calibration words never wait on it.
module bldc_hall_block_commutation_unit #(
    parameter int FILTER_BITS   = 12,
    parameter int PWM_PERIOD    = 2250,
    parameter int CALIB_ITEMS   = 1000,
    parameter int SPEED_TIMEOUT = 4000
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  bhc_pkg::adc_t   cfg_wr_data,
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            hall_a,
    input  logic            hall_b,
    input  logic            hall_c,
    input  bhc_pkg::adc_t   current_sample,
    input  logic            enable,
    input  logic            timed_out,
    input  bhc_pkg::cmd_t   pwm_command,
    output logic            out_valid,
    input  logic            out_stall,
    output bhc_pkg::duty_t  duty_a,
    output bhc_pkg::duty_t  duty_b,
    output bhc_pkg::duty_t  duty_c,
    output logic            output_on,
    output bhc_pkg::pos_t   position,
    output logic signed [31:0] odometer,
    output logic [11:0]     speed_period,
    output logic            speed_reverse
);
    import bhc_pkg::*;

    localparam duty_t HALF     = duty_t'(PWM_PERIOD / 2);
    localparam duty_t DUTY_HI  = duty_t'(PWM_PERIOD - DUTY_MARGIN);
    localparam logic [9:0]  CALIB_N = 10'(CALIB_ITEMS);
    localparam logic [11:0] SPD_TO  = 12'(SPEED_TIMEOUT);

    // configuration and state
    adc_t               limit_reg;
    adc_t               offset_reg, offset_next;
    logic [9:0]         calib_reg;
    logic signed [31:0] acc_reg, acc_next;
    pos_t               last_pos_reg;
    logic signed [31:0] odo_reg, odo_next;
    logic [11:0]        spd_cnt_reg, spd_cnt_next;
    logic [11:0]        period_reg, period_next;
    logic               rev_reg, rev_next;

    // input register
    logic        s1_valid_reg;
    logic [2:0]  s1_hall_reg;
    adc_t        s1_sample_reg;
    logic        s1_en_reg;
    logic        s1_to_reg;
    cmd_t        s1_cmd_reg;

    // output register
    logic        out_valid_reg;
    duty_t       duty_a_reg, duty_b_reg, duty_c_reg;
    logic        on_reg;
    pos_t        pos_reg;

    logic calib_active, s1_adv, s1_fire, in_take;

    assign calib_active = calib_reg < CALIB_N;
    assign s1_adv       = !out_valid_reg || !out_stall || calib_active;
    assign s1_fire      = s1_valid_reg && s1_adv && !calib_active;
    assign in_stall     = s1_valid_reg && !s1_adv;
    assign in_take      = in_valid && !in_stall;

    // command scaling by 9/8 toward zero, then clamp
    logic signed [15:0] cmd9;
    logic signed [15:0] cmd_div;
    logic signed [15:0] cmd_lim;
    logic signed [12:0] sdiff;
    adc_t               adiff;
    logic signed [31:0] filt;
    phase_t             fsat, ph_a, ph_b, ph_c;
    pos_t               pos;
    logic               on;
    logic [11:0]        spd_inc;

    always_comb
    begin
        cmd9 = ($signed(16'(s1_cmd_reg)) <<< 3) + $signed(16'(s1_cmd_reg));
        if (cmd9 < 0)
            cmd_div = (cmd9 + 16'sd7) >>> 3;
        else
            cmd_div = cmd9 >>> 3;
        if (cmd_div > 16'(CMD_LIMIT))
            cmd_lim = 16'(CMD_LIMIT);
        else if (cmd_div < -16'(CMD_LIMIT))
            cmd_lim = -16'(CMD_LIMIT);
        else
            cmd_lim = cmd_div;

        sdiff = $signed({1'b0, s1_sample_reg}) - $signed({1'b0, offset_reg});
        adiff = (sdiff < 0) ? 12'(-sdiff) : sdiff[11:0];
        on    = !(adiff > limit_reg) && s1_en_reg && !s1_to_reg;

        pos = hall_step(s1_hall_reg);

        acc_next = acc_reg - (acc_reg >>> FILTER_BITS) + 32'(cmd_lim);
        filt     = acc_next >>> FILTER_BITS;
        // beyond this range every duty clamps the same way
        if (filt > 32'sd4095)
            fsat = 13'(PHASE_SAT);
        else if (filt < -32'sd4095)
            fsat = -13'(PHASE_SAT);
        else
            fsat = filt[12:0];

        ph_a = '0;
        ph_b = '0;
        ph_c = '0;
        case (pos)
            POS_1:
            begin
                ph_b = fsat;
                ph_c = -fsat;
            end
            POS_2:
            begin
                ph_a = -fsat;
                ph_b = fsat;
            end
            POS_3:
            begin
                ph_a = -fsat;
                ph_c = fsat;
            end
            POS_4:
            begin
                ph_b = -fsat;
                ph_c = fsat;
            end
            POS_5:
            begin
                ph_a = fsat;
                ph_b = -fsat;
            end
            POS_6:
            begin
                ph_a = fsat;
                ph_c = -fsat;
            end
            default:
            begin
                ph_a = '0;
            end
        endcase

        odo_next = odo_reg + 32'(odo_step(last_pos_reg, pos));

        spd_inc = (spd_cnt_reg < SPD_TO) ? spd_cnt_reg + 12'd1 : spd_cnt_reg;
        if (last_pos_reg != POS_1 && pos == POS_1)
        begin
            period_next  = spd_inc;
            rev_next     = (last_pos_reg == POS_2);
            spd_cnt_next = '0;
        end
        else if (spd_inc >= SPD_TO)
        begin
            period_next  = '0;
            rev_next     = 1'b0;
            spd_cnt_next = spd_inc;
        end
        else
        begin
            period_next  = period_reg;
            rev_next     = rev_reg;
            spd_cnt_next = spd_inc;
        end

        offset_next = 12'(({1'b0, s1_sample_reg} + {1'b0, offset_reg}) >> 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            offset_reg    <= OFFSET_RESET;
            calib_reg     <= '0;
            acc_reg       <= '0;
            last_pos_reg  <= POS_NONE;
            odo_reg       <= '0;
            spd_cnt_reg   <= '0;
            period_reg    <= '0;
            rev_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;

            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_valid_reg && calib_active)
            begin
                calib_reg  <= calib_reg + 10'd1;
                offset_reg <= offset_next;
            end

            if (s1_fire)
            begin
                acc_reg      <= acc_next;
                last_pos_reg <= pos;
                odo_reg      <= odo_next;
                spd_cnt_reg  <= spd_cnt_next;
                period_reg   <= period_next;
                rev_reg      <= rev_next;
            end

            if (s1_fire)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_hall_reg   <= {hall_c, hall_b, hall_a};
            s1_sample_reg <= current_sample;
            s1_en_reg     <= enable;
            s1_to_reg     <= timed_out;
            s1_cmd_reg    <= pwm_command;
        end
        if (s1_fire)
        begin
            duty_a_reg <= duty_clamp(ph_a, HALF, DUTY_HI);
            duty_b_reg <= duty_clamp(ph_b, HALF, DUTY_HI);
            duty_c_reg <= duty_clamp(ph_c, HALF, DUTY_HI);
            on_reg     <= on;
            pos_reg    <= pos;
        end
    end

    assign out_valid     = out_valid_reg;
    assign duty_a        = duty_a_reg;
    assign duty_b        = duty_b_reg;
    assign duty_c        = duty_c_reg;
    assign output_on     = on_reg;
    assign position      = pos_reg;
    assign odometer      = odo_reg;
    assign speed_period  = period_reg;
    assign speed_reverse = rev_reg;

    logic duty_a_ok, duty_b_ok, duty_c_ok, all_half;

    assign duty_a_ok = duty_a >= duty_t'(DUTY_MARGIN) && duty_a <= DUTY_HI;
    assign duty_b_ok = duty_b >= duty_t'(DUTY_MARGIN) && duty_b <= DUTY_HI;
    assign duty_c_ok = duty_c >= duty_t'(DUTY_MARGIN) && duty_c <= DUTY_HI;
    assign all_half  = duty_a == HALF && duty_b == HALF && duty_c == HALF;

    // calibration words never produce an output word
    `BHC_ASSERT(a_calib_silent, s1_valid_reg && calib_active && !out_valid_reg |=> !out_valid_reg)
    // invalid hall code parks every phase at the half period
    `BHC_ASSERT(a_park_half, out_valid && position == POS_NONE |-> all_half)
    `BHC_ASSERT(a_duty_range, out_valid |-> duty_a_ok && duty_b_ok && duty_c_ok)
    `BHC_NEVER(a_calib_over, calib_reg > CALIB_N)
    // a held period is never beyond the timeout
    `BHC_NEVER(a_period_range, period_reg > SPD_TO)
    // a timed-out counter carries no direction
    `BHC_NEVER(a_timeout_dir, rev_reg && spd_cnt_reg >= SPD_TO)

endmodule
